// ===== rtl/tflh_pkg.sv =====
`default_nettype none
package tflh_pkg;

  localparam int LEVEL_COUNT_DEF = 4;
  localparam int MAX_LEVELS      = 8;
  localparam int TEMP_W          = 8;
  localparam int SENSORS         = 4;
  localparam int RPM_W           = 13;
  localparam int FAN_W           = 2;
  localparam int ROW_W           = 4;
  localparam int IN_DATA_W       = 32;
  localparam int OUT_DATA_W      = 16;

  // Sensor order inside a sample.
  localparam logic [1:0] S_SOC     = 2'd0;
  localparam logic [1:0] S_CHARGER = 2'd1;
  localparam logic [1:0] S_WWAN    = 2'd2;
  localparam logic [1:0] S_DDR     = 2'd3;

  typedef logic signed [TEMP_W-1:0] temp_t;

  typedef enum logic [1:0] {
    DIR_HOLD = 2'd0,
    DIR_DOWN = 2'd1,
    DIR_UP   = 2'd2
  } dir_t;

  // Levels from three up all share the top row.
  function automatic temp_t row_on(input logic [ROW_W-1:0] r, input logic [1:0] s);
    temp_t v;
    v = 8'sd100;
    case (r)
      4'd0: begin
        case (s)
          S_SOC:     v = 8'sd47;
          S_CHARGER: v = 8'sd62;
          S_WWAN:    v = 8'sd48;
          default:   v = 8'sd50;
        endcase
      end
      4'd1: begin
        case (s)
          S_SOC:     v = 8'sd49;
          S_CHARGER: v = 8'sd62;
          S_WWAN:    v = 8'sd50;
          default:   v = 8'sd52;
        endcase
      end
      4'd2: begin
        case (s)
          S_SOC:     v = 8'sd51;
          S_CHARGER: v = 8'sd62;
          S_WWAN:    v = 8'sd53;
          default:   v = 8'sd54;
        endcase
      end
      default: v = 8'sd100;
    endcase
    return v;
  endfunction

  function automatic temp_t row_off(input logic [ROW_W-1:0] r, input logic [1:0] s);
    temp_t v;
    v = 8'sd99;
    case (r)
      4'd0: v = 8'sd99;
      4'd1: begin
        case (s)
          S_SOC:     v = 8'sd46;
          S_CHARGER: v = 8'sd99;
          S_WWAN:    v = 8'sd47;
          default:   v = 8'sd49;
        endcase
      end
      4'd2: begin
        case (s)
          S_SOC:     v = 8'sd48;
          S_CHARGER: v = 8'sd99;
          S_WWAN:    v = 8'sd49;
          default:   v = 8'sd51;
        endcase
      end
      default: begin
        case (s)
          S_SOC:     v = 8'sd50;
          S_CHARGER: v = 8'sd60;
          S_WWAN:    v = 8'sd51;
          default:   v = 8'sd52;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [RPM_W-1:0] row_rpm(input logic [ROW_W-1:0] r);
    logic [RPM_W-1:0] v;
    case (r)
      4'd0:    v = 13'd0;
      4'd1:    v = 13'd3100;
      4'd2:    v = 13'd3750;
      default: v = 13'd5100;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/thermal_fan_level_hysteresis_core.sv =====
// Flow: a sample whose temperatures moved goes from request through ST_STEP, which takes one
// level step at a time (at most LEVEL_COUNT steps), to ST_FIN; an inactive or unchanged sample
// goes straight to ST_FIN. Throughput: one sample at a time, set by the single threshold compare
// unit that checks one level per cycle; the next request is taken in the cycle after the result
// is registered and not before, so a stall on the result side, which holds ST_FIN, delays it.
// Reset (rst, synchronous): fan level zero, stored temperatures zero, no result pending.
`default_nettype none
module thermal_fan_level_hysteresis_core import tflh_pkg::*; #(
  parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // temp_soc [7:0], temp_charger [15:8], temp_wwan [23:16], temp_ddr [31:24]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // system_active [0]
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // rpm_target [12:0], fan_level [14:13], zero [15]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // apply [0]
  output logic                  m_tuser
);

  localparam int LW  = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam int CW  = $clog2(LEVEL_COUNT + 1);
  localparam int TOP = LEVEL_COUNT - 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_STEP = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [LW-1:0]    level_now;
  temp_t            last_temps [SENSORS];
  temp_t            in_temps [SENSORS];
  logic [CW-1:0]    lv;
  logic [CW-1:0]    lv_step;
  logic [CW-1:0]    lv_clamp;
  logic [CW-1:0]    top_lv;
  dir_t             dir;
  dir_t             dir_next;
  logic             act;
  logic             move;
  logic             fell;
  logic             rose;
  logic             accept;
  logic             out_free;

  assign top_lv   = CW'(TOP);
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign lv_clamp = (lv > top_lv) ? top_lv : lv;

  always_comb begin
    for (int i = 0; i < SENSORS; i++) begin
      in_temps[i] = s_tdata[i*TEMP_W +: TEMP_W];
    end
    fell = 1'b0;
    rose = 1'b0;
    for (int i = 0; i < SENSORS; i++) begin
      if (in_temps[i] < last_temps[i]) fell = 1'b1;
      if (in_temps[i] > last_temps[i]) rose = 1'b1;
    end
    if (fell) begin
      dir_next = DIR_DOWN;
    end else if (rose) begin
      dir_next = DIR_UP;
    end else begin
      dir_next = DIR_HOLD;
    end
  end

  // The stored sample doubles as the working sample while the level walks.
  tflh_step #(.CW(CW)) u_step (
    .temps   (last_temps),
    .lv      (lv),
    .top     (top_lv),
    .dir     (dir),
    .lv_next (lv_step),
    .move    (move)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (s_tuser && dir_next != DIR_HOLD) ? ST_STEP : ST_FIN;
        end
      end
      ST_STEP: begin
        if (!move) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      level_now <= '0;
      m_tvalid  <= 1'b0;
      for (int i = 0; i < SENSORS; i++) begin
        last_temps[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == ST_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && s_tuser) begin
            for (int i = 0; i < SENSORS; i++) begin
              last_temps[i] <= in_temps[i];
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            level_now <= LW'(lv_clamp);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lv  <= CW'(level_now);
      dir <= dir_next;
      act <= s_tuser;
    end else if (state == ST_STEP && move) begin
      lv <= lv_step;
    end
    if (state == ST_FIN && out_free) begin
      m_tdata <= {1'b0, FAN_W'(lv_clamp), row_rpm(ROW_W'(lv_clamp))};
      m_tuser <= act;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tflh_step.sv =====
`default_nettype none
module tflh_step import tflh_pkg::*; #(
  parameter int CW = 3
) (
  input  temp_t          temps [SENSORS],
  input  logic [CW-1:0]  lv,
  input  logic [CW-1:0]  top,
  input  dir_t           dir,
  output logic [CW-1:0]  lv_next,
  output logic           move
);

  logic [ROW_W-1:0] row;
  logic             down_ok;
  logic             up_ok;

  assign row = ROW_W'(lv);

  always_comb begin
    down_ok = (temps[S_SOC]     < row_off(row, S_SOC))     &&
              (temps[S_CHARGER] < row_off(row, S_CHARGER)) &&
              (temps[S_WWAN]    < row_off(row, S_WWAN))    &&
              (temps[S_DDR]     < row_off(row, S_DDR));
    up_ok   = (temps[S_SOC] > row_on(row, S_SOC)) ||
              ((temps[S_CHARGER] > row_on(row, S_CHARGER)) &&
               (temps[S_WWAN]    > row_on(row, S_WWAN))) ||
              (temps[S_DDR] > row_on(row, S_DDR));
  end

  always_comb begin
    move    = 1'b0;
    lv_next = lv;
    case (dir)
      DIR_DOWN: begin
        move    = (lv != '0) && down_ok;
        lv_next = lv - CW'(1);
      end
      DIR_UP: begin
        move    = (lv <= top) && up_ok;
        lv_next = lv + CW'(1);
      end
      default: begin
        move    = 1'b0;
        lv_next = lv;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import tflh_pkg::*;

  localparam int TOP_LEVEL   = LEVEL_COUNT_DEF - 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQS = 600;
  localparam int CALM_REQS   = 100;

  typedef struct packed {
    temp_t soc;
    temp_t chg;
    temp_t wwan;
    temp_t ddr;
    logic  active;
  } sample_t;

  typedef struct packed {
    logic [RPM_W-1:0] rpm;
    logic [FAN_W-1:0] level;
    logic             apply;
  } fan_res_t;

  typedef struct packed {
    sample_t  smp;
    logic     typed;
    fan_res_t res;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  // Per-level thresholds, sensors in the order soc, charger, wwan, ddr.
  temp_t on_thr [0:3][0:3] = '{
    '{8'sd47, 8'sd62, 8'sd48, 8'sd50},
    '{8'sd49, 8'sd62, 8'sd50, 8'sd52},
    '{8'sd51, 8'sd62, 8'sd53, 8'sd54},
    '{8'sd100, 8'sd100, 8'sd100, 8'sd100}
  };
  temp_t off_thr [0:3][0:3] = '{
    '{8'sd99, 8'sd99, 8'sd99, 8'sd99},
    '{8'sd46, 8'sd99, 8'sd47, 8'sd49},
    '{8'sd48, 8'sd99, 8'sd49, 8'sd51},
    '{8'sd50, 8'sd60, 8'sd51, 8'sd52}
  };
  logic [RPM_W-1:0] level_rpm [0:3] = '{13'd0, 13'd3100, 13'd3750, 13'd5100};

  int        level_state;
  temp_t     prior_temps [0:3];
  fan_res_t  pending_fan [$];
  stim_row_t stim_rows [$];
  sample_t   last_sample;
  int        err_count;
  int        cycle_count;
  bit        calm;

  thermal_fan_level_hysteresis_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic fan_res_t predict_fan_step(input sample_t smp);
    fan_res_t r;
    temp_t    tv [0:3];
    logic     fell;
    logic     rose;
    int       lv;
    tv[0] = smp.soc;
    tv[1] = smp.chg;
    tv[2] = smp.wwan;
    tv[3] = smp.ddr;
    if (smp.active) begin
      fell = 1'b0;
      rose = 1'b0;
      for (int i = 0; i < 4; i++) begin
        if (tv[i] < prior_temps[i]) fell = 1'b1;
        if (tv[i] > prior_temps[i]) rose = 1'b1;
      end
      lv = level_state;
      // A fall anywhere takes the down path, even if other sensors rose.
      if (fell) begin
        while (lv > 0 && tv[0] < off_thr[lv][0] && tv[1] < off_thr[lv][1] &&
               tv[2] < off_thr[lv][2] && tv[3] < off_thr[lv][3])
          lv--;
      end else if (rose) begin
        while (lv <= TOP_LEVEL && (tv[0] > on_thr[lv][0] ||
               (tv[1] > on_thr[lv][1] && tv[2] > on_thr[lv][2]) || tv[3] > on_thr[lv][3]))
          lv++;
      end
      if (lv > TOP_LEVEL) lv = TOP_LEVEL;
      level_state = lv;
      for (int i = 0; i < 4; i++) prior_temps[i] = tv[i];
    end
    r.rpm   = level_rpm[level_state];
    r.level = level_state[FAN_W-1:0];
    r.apply = smp.active;
    return r;
  endfunction

  function automatic sample_t make_sample(input int soc, input int chg, input int wwan,
                                          input int ddr, input bit act);
    sample_t s;
    s.soc    = 8'(soc);
    s.chg    = 8'(chg);
    s.wwan   = 8'(wwan);
    s.ddr    = 8'(ddr);
    s.active = act;
    return s;
  endfunction

  task automatic add_row(input int soc, input int chg, input int wwan, input int ddr,
                         input bit act, input bit typed, input int rpm, input int lvl);
    stim_row_t row;
    row.smp       = make_sample(soc, chg, wwan, ddr, act);
    row.typed     = typed;
    row.res.rpm   = RPM_W'(rpm);
    row.res.level = FAN_W'(lvl);
    row.res.apply = act;
    stim_rows.push_back(row);
  endtask

  function automatic temp_t pick_temp(input int mode, input temp_t prev);
    temp_t t;
    case (mode)
      0, 1, 2, 3, 4: t = 8'($urandom_range(38, 66));
      5: t = 8'(int'(prev) + $urandom_range(0, 6) - 3);
      6, 7: t = 8'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: t = -8'sd128;
          1: t = 8'sd127;
          2: t = 8'sd0;
          default: t = -8'sd1;
        endcase
      end
    endcase
    return t;
  endfunction

  function automatic sample_t random_sample(input sample_t prev);
    sample_t s;
    int      mode;
    mode = $urandom_range(0, 9);
    if (mode == 9) begin
      // Same sample again: no change, the level holds.
      s = prev;
    end else begin
      s.soc  = pick_temp(mode, prev.soc);
      s.chg  = pick_temp(mode, prev.chg);
      s.wwan = pick_temp(mode, prev.wwan);
      s.ddr  = pick_temp(mode, prev.ddr);
    end
    s.active = ($urandom_range(0, 7) != 0);
    return s;
  endfunction

  task automatic send_sample(input sample_t smp, input bit typed, input fan_res_t want);
    fan_res_t pred;
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {smp.ddr, smp.wwan, smp.chg, smp.soc};
    s_tuser  <= smp.active;
    do @(posedge clk); while (!s_tready);
    pred = predict_fan_step(smp);
    pending_fan.push_back(typed ? want : pred);
    last_sample = smp;
  endtask

  initial begin
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tuser     <= 1'b0;
    rst         <= 1'b1;
    level_state = 0;
    for (int i = 0; i < 4; i++) prior_temps[i] = '0;
    err_count   = 0;
    calm        = 1'b0;

    add_row( 127,  127,  127,  127, 1'b0, 1'b1,    0, 0);
    add_row(   0,    0,    0,    0, 1'b1, 1'b1,    0, 0);
    add_row( 127,    0,    0,    0, 1'b1, 1'b1, 5100, 3);
    add_row(-128, -128, -128, -128, 1'b0, 1'b1, 5100, 3);
    add_row(-128, -128, -128, -128, 1'b1, 1'b1,    0, 0);
    add_row(  50,   50,   50,   50, 1'b1, 1'b0,    0, 0);
    add_row( 127,   50,   50,   49, 1'b1, 1'b0,    0, 0);
    add_row(   0,    0,    0,    0, 1'b1, 1'b0,    0, 0);
    add_row(   0,   63,   49,    0, 1'b1, 1'b0,    0, 0);
    add_row(   0,   63,    0,    0, 1'b1, 1'b0,    0, 0);
    add_row(   0,  127,  127,    0, 1'b1, 1'b0,    0, 0);
    add_row(   0,   63,  127,    0, 1'b1, 1'b0,    0, 0);
    add_row(   0,   63,  127,    0, 1'b1, 1'b0,    0, 0);
    add_row(   0,    0,    0,    0, 1'b1, 1'b0,    0, 0);
    add_row(   0,    0,    0,   55, 1'b1, 1'b0,    0, 0);
    add_row(  47,    0,    0,   50, 1'b1, 1'b0,    0, 0);
    add_row(  -1,   -1,   -1,   -1, 1'b1, 1'b0,    0, 0);
    add_row(  48,   62,   48,    0, 1'b1, 1'b0,    0, 0);
    add_row( 127,  -86,   85, -128, 1'b1, 1'b0,    0, 0);
    add_row( -86,   85, -128,  127, 1'b1, 1'b0,    0, 0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) send_sample(stim_rows[i].smp, stim_rows[i].typed, stim_rows[i].res);
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS - CALM_REQS) calm = 1'b1;
      send_sample(random_sample(last_sample), 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    while (pending_fan.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Result side stalls in bursts until the final stretch of the run.
  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    fan_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_fan.size() == 0) begin
        $error("unexpected result: m_tdata %0h, m_tuser %0b", m_tdata, m_tuser);
        err_count++;
      end else begin
        want = pending_fan.pop_front();
        if (m_tdata[RPM_W-1:0] != want.rpm) begin
          $error("rpm_target: expected %0d, got %0d", want.rpm, m_tdata[RPM_W-1:0]);
          err_count++;
        end
        if (m_tdata[RPM_W+FAN_W-1:RPM_W] != want.level) begin
          $error("fan_level: expected %0d, got %0d", want.level,
                 m_tdata[RPM_W+FAN_W-1:RPM_W]);
          err_count++;
        end
        if (m_tdata[OUT_DATA_W-1] != 1'b0) begin
          $error("zero: expected 0, got %0b", m_tdata[OUT_DATA_W-1]);
          err_count++;
        end
        if (m_tuser != want.apply) begin
          $error("apply: expected %0b, got %0b", want.apply, m_tuser);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
